FILE: rtl/tpg_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and the div3 helper function of the test pattern pixel generator.
// Used by tpg_div_cell, test_pattern_pixel_generator_top and its testbench; depends on nothing else.
package tpg_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned REM_W    = 20;
  localparam int unsigned QUOT_W   = 8;
  localparam int unsigned OFFSET_W = 25;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ROW_PITCH    = 2'd2,
    REG_BLUE_FIRST   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [23:0]         pixel_word;
    logic [OFFSET_W-1:0] word_offset;
    logic                inside_res;
  } out_t;

  // Data that travels down the divider chain, one entry per pixel in flight.
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [REM_W-1:0]    rem_r;
    logic [REM_W-1:0]    rem_g;
    logic [QUOT_W-1:0]   q_r;
    logic [QUOT_W-1:0]   q_g;
    logic                odd;
    logic [OFFSET_W-1:0] offset;
  } lane_t;

  // Exact floor(v / 3) for any 16-bit v, by reciprocal multiplication.
  function automatic logic [15:0] div3(input logic [15:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'(17'd43691);
    return 16'(p >> 17);
  endfunction

endpackage

FILE: rtl/tpg_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step for the red and green gradients, registered.
// Depends on tpg_pkg for the lane type.
module tpg_div_cell #(
  parameter int unsigned SHIFT = 7,
  parameter int unsigned DW    = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  tpg_pkg::lane_t       lane_i,
  input  logic [DW-1:0]        div_w,
  input  logic [DW-1:0]        div_h,
  output logic                 vld_o,
  output tpg_pkg::lane_t       lane_o
);

  localparam int unsigned CW = ((DW + SHIFT) > tpg_pkg::REM_W) ? (DW + SHIFT) : tpg_pkg::REM_W;

  logic                 vld_r;
  tpg_pkg::lane_t       lane_r;
  tpg_pkg::lane_t       lane_nxt;
  logic [CW-1:0]        sub_w;
  logic [CW-1:0]        sub_h;
  logic [CW-1:0]        rem_w_ext;
  logic [CW-1:0]        rem_h_ext;

  always_comb begin
    sub_w     = CW'(div_w) << SHIFT;
    sub_h     = CW'(div_h) << SHIFT;
    rem_w_ext = CW'(lane_i.rem_r);
    rem_h_ext = CW'(lane_i.rem_g);
    lane_nxt  = lane_i;
    if (rem_w_ext >= sub_w) begin
      lane_nxt.rem_r     = tpg_pkg::REM_W'(rem_w_ext - sub_w);
      lane_nxt.q_r[SHIFT] = 1'b1;
    end
    if (rem_h_ext >= sub_h) begin
      lane_nxt.rem_g     = tpg_pkg::REM_W'(rem_h_ext - sub_h);
      lane_nxt.q_g[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

FILE: rtl/test_pattern_pixel_generator_top.sv
`timescale 1ns / 1ps
// Top level of the test pattern pixel generator: APB register file, input stage,
// gradient divider chain of tpg_div_cell instances and output stage. Depends on tpg_pkg.
//
// Usage: drive a pixel coordinate on in_data and raise start; the transaction is
// taken at a rising edge with start high and busy low. A new coordinate can be
// taken in every cycle while busy is low. Each accepted coordinate yields exactly
// one result on out_data, marked by out_strobe for a single cycle, in the order
// the coordinates came in. Each coordinate passes through one input register,
// eight division cells (one quotient bit each for the red and green gradients)
// and one output register. The receiver cannot stall the result channel, so
// results are never held back or dropped.
// The frame geometry and color order are set through the APB port at byte
// addresses 0, 4, 8 and 12; writes take effect for coordinates accepted after
// them and must only occur while no transaction is in flight.
// Reset (rst_n low, synchronous) restores 640 x 480, pitch 640, RGB order,
// empties the pipeline and holds busy high until the first edge that samples rst_n high.
module test_pattern_pixel_generator_top #(
  parameter int unsigned MAX_WIDTH  = tpg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = tpg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tpg_pkg::in_t                in_data,
  output logic                        out_strobe,
  output tpg_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpg_pkg::DATA_W-1:0]  pwdata,
  output logic [tpg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW    = (WW > HW) ? WW : HW;
  localparam int unsigned STEPS = tpg_pkg::QUOT_W;

  logic [12:0]  frame_width_r;
  logic [12:0]  frame_height_r;
  logic [13:0]  row_pitch_r;
  logic         blue_first_r;
  logic         busy_r;
  tpg_pkg::reg_idx_t reg_idx;
  logic         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = tpg_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd640;
      frame_height_r <= 13'd480;
      row_pitch_r    <= 14'd640;
      blue_first_r   <= 1'b0;
      busy_r         <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr) begin
        unique case (reg_idx)
          tpg_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[12:0];
          tpg_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[12:0];
          tpg_pkg::REG_ROW_PITCH:    row_pitch_r    <= pwdata[13:0];
          tpg_pkg::REG_BLUE_FIRST:   blue_first_r   <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      tpg_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      tpg_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      tpg_pkg::REG_ROW_PITCH:    prdata = 32'(row_pitch_r);
      tpg_pkg::REG_BLUE_FIRST:   prdata = 32'(blue_first_r);
      default:                   prdata = '0;
    endcase
  end

  // Geometry from the registers; users keep it stable while transactions are in flight.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [16:0]   w5;
  logic [WW-1:0] w_eff_r;
  logic [HW-1:0] h_eff_r;
  logic [WW-1:0] wm1_r;
  logic [HW-1:0] hm1_r;
  logic [HW-1:0] h3_r;
  logic [HW-1:0] h23_r;
  logic [WW-1:0] w6_r;
  logic [WW-1:0] w56_r;
  logic          w_le1_r;
  logic          h_le1_r;

  always_comb begin
    w_eff = (32'(frame_width_r) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width_r);
    h_eff = (32'(frame_height_r) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(frame_height_r);
    w5    = (17'(w_eff) << 2) + 17'(w_eff);
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_eff;
    h_eff_r <= h_eff;
    wm1_r   <= w_eff - WW'(1);
    hm1_r   <= h_eff - HW'(1);
    h3_r    <= HW'(tpg_pkg::div3(16'(h_eff)));
    h23_r   <= HW'(tpg_pkg::div3(16'(17'(h_eff) << 1)));
    w6_r    <= WW'(tpg_pkg::div3(16'(w_eff >> 1)));
    w56_r   <= WW'(tpg_pkg::div3(16'(w5 >> 1)));
    w_le1_r <= (32'(w_eff) <= 32'd1);
    h_le1_r <= (32'(h_eff) <= 32'd1);
  end

  // Input stage: dividends, checker parity and word offset.
  logic            in_vld_r;
  tpg_pkg::lane_t  in_lane_r;
  tpg_pkg::lane_t  in_lane_nxt;
  logic [15:0]     cx;
  logic [15:0]     cy;
  logic [25:0]     offs;
  logic            accept;

  assign accept = start && !busy_r;

  always_comb begin
    cx   = tpg_pkg::div3(16'(in_data.pixel_x[11:4]));
    cy   = tpg_pkg::div3(16'(in_data.pixel_y[11:4]));
    offs = 26'(in_data.pixel_y) * 26'(row_pitch_r) + 26'(in_data.pixel_x);
    in_lane_nxt.x      = in_data.pixel_x;
    in_lane_nxt.y      = in_data.pixel_y;
    in_lane_nxt.rem_r  = (20'(in_data.pixel_x) << 8) - 20'(in_data.pixel_x);
    in_lane_nxt.rem_g  = (20'(in_data.pixel_y) << 8) - 20'(in_data.pixel_y);
    in_lane_nxt.q_r    = '0;
    in_lane_nxt.q_g    = '0;
    in_lane_nxt.odd    = cx[0] ^ cy[0];
    in_lane_nxt.offset = offs[tpg_pkg::OFFSET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_lane_r <= in_lane_nxt;
  end

  // Divider chain.
  logic            vld_s  [STEPS+1];
  tpg_pkg::lane_t  lane_s [STEPS+1];

  assign vld_s[0]  = in_vld_r;
  assign lane_s[0] = in_lane_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    tpg_div_cell #(
      .SHIFT (STEPS - 1 - i),
      .DW    (DW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_s[i]),
      .lane_i (lane_s[i]),
      .div_w  (DW'(wm1_r)),
      .div_h  (DW'(hm1_r)),
      .vld_o  (vld_s[i+1]),
      .lane_o (lane_s[i+1])
    );
  end

  // Output stage: layer selection and packing.
  tpg_pkg::lane_t lane_e;
  logic           in_frame;
  logic           band;
  logic           border;
  logic [7:0]     red;
  logic [7:0]     green;
  logic [7:0]     blue;
  logic [23:0]    word;
  logic           out_strobe_r;
  tpg_pkg::out_t  out_data_r;
  tpg_pkg::out_t  out_data_nxt;

  always_comb begin
    lane_e   = lane_s[STEPS];
    in_frame = (32'(lane_e.x) < 32'(w_eff_r)) && (32'(lane_e.y) < 32'(h_eff_r));
    band   = (32'(lane_e.y) >= 32'(h3_r)) && (32'(lane_e.y) < 32'(h23_r)) &&
             (32'(lane_e.x) >= 32'(w6_r)) && (32'(lane_e.x) < 32'(w56_r));
    border = (lane_e.x == '0) || (32'(lane_e.x) == 32'(wm1_r)) ||
             (lane_e.y == '0) || (32'(lane_e.y) == 32'(hm1_r));
    red    = w_le1_r ? 8'd0 : lane_e.q_r;
    green  = h_le1_r ? 8'd0 : lane_e.q_g;
    blue   = lane_e.x[7:0] ^ lane_e.y[7:0];
    if (lane_e.odd) begin
      red   = 8'd255 - red;
      green = 8'd255 - green;
    end
    if (band) begin
      red   = 8'd32;
      green = 8'd160;
      blue  = 8'd255;
    end else if (border) begin
      red   = 8'd255;
      green = 8'd255;
      blue  = 8'd255;
    end
    if (!in_frame) begin
      word = '0;
    end else if (blue_first_r) begin
      word = {blue, green, red};
    end else begin
      word = {red, green, blue};
    end
    out_data_nxt.pixel_word  = word;
    out_data_nxt.word_offset = lane_e.offset;
    out_data_nxt.inside_res  = in_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_s[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_vld_r)
    else $error("accepted transaction did not enter the input stage");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |-> ##9 out_strobe_r)
    else $error("transaction did not reach the result port after nine cycles");

  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_data_r.inside_res) |-> (out_data_r.pixel_word == '0))
    else $error("outside coordinate produced a nonzero pixel");

  a_red_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_s[STEPS] && in_frame && !w_le1_r) |-> (32'(lane_e.rem_r) < 32'(wm1_r)))
    else $error("red gradient remainder not below divisor");

  a_green_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_s[STEPS] && in_frame && !h_le1_r) |-> (32'(lane_e.rem_g) < 32'(hm1_r)))
    else $error("green gradient remainder not below divisor");

endmodule

FILE: dv/test_pattern_pixel_generator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for test_pattern_pixel_generator_top: sends pixel coordinates under
// several frame geometries and color orders, and checks every pixel against a local predictor.
// Depends on tpg_pkg and the RTL of test_pattern_pixel_generator_top only.
module test_pattern_pixel_generator_top_tb;

  localparam int unsigned MAX_W = tpg_pkg::MAX_WIDTH_DEF;
  localparam int unsigned MAX_H = tpg_pkg::MAX_HEIGHT_DEF;
  localparam int unsigned CHECKER = 48;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  tpg_pkg::in_t               in_data = '0;
  logic                       out_strobe;
  tpg_pkg::out_t              out_data;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [tpg_pkg::ADDR_W-1:0] paddr = '0;
  logic [tpg_pkg::DATA_W-1:0] pwdata = '0;
  logic [tpg_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  logic [12:0] frame_w_cfg = 13'd640;
  logic [12:0] frame_h_cfg = 13'd480;
  logic [13:0] pitch_cfg   = 14'd640;
  logic        bgr_cfg     = 1'b0;

  tpg_pkg::in_t  coord_queue[$];
  tpg_pkg::out_t expected_pixels[$];
  int unsigned   sender_idle_pct = 0;
  int unsigned   fail_count = 0;

  test_pattern_pixel_generator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  function automatic int unsigned gradient_level(int unsigned pos, int unsigned extent);
    if (extent <= 1) begin
      return 0;
    end
    return (pos * 255) / (extent - 1);
  endfunction

  function automatic tpg_pkg::out_t predict_pixel(tpg_pkg::in_t c);
    int unsigned   x;
    int unsigned   y;
    int unsigned   w;
    int unsigned   h;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic          band;
    logic          border;
    tpg_pkg::out_t res;
    x = c.pixel_x;
    y = c.pixel_y;
    w = (frame_w_cfg > MAX_W) ? MAX_W : frame_w_cfg;
    h = (frame_h_cfg > MAX_H) ? MAX_H : frame_h_cfg;
    res = '0;
    res.word_offset = tpg_pkg::OFFSET_W'(y * pitch_cfg + x);
    res.inside_res = (x < w) && (y < h);
    if (res.inside_res) begin
      band = (y >= h / 3) && (y < (h * 2) / 3) && (x >= w / 6) && (x < (w * 5) / 6);
      border = (x == 0) || (x == w - 1) || (y == 0) || (y == h - 1);
      if (band) begin
        r = 8'd32;
        g = 8'd160;
        b = 8'd255;
      end else if (border) begin
        r = 8'd255;
        g = 8'd255;
        b = 8'd255;
      end else begin
        r = 8'(gradient_level(x, w));
        g = 8'(gradient_level(y, h));
        b = 8'(x ^ y);
        if (((x / CHECKER + y / CHECKER) & 1) != 0) begin
          r = 8'd255 - r;
          g = 8'd255 - g;
        end
      end
      res.pixel_word = bgr_cfg ? {b, g, r} : {r, g, b};
    end
    return res;
  endfunction

  // Sender: one coordinate is taken per handshake, predicted at that edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_pixels.push_back(predict_pixel(in_data));
        void'(coord_queue.pop_front());
      end
      if (!start || !busy) begin
        if (coord_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          start <= 1'b1;
          in_data <= coord_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tpg_pkg::out_t exp_px;
    if (rst_n && out_strobe) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected transaction on the result port: %p", out_data);
        fail_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_data.pixel_word !== exp_px.pixel_word) begin
          $error("pixel_word: expected %h, got %h", exp_px.pixel_word, out_data.pixel_word);
          fail_count++;
        end
        if (out_data.word_offset !== exp_px.word_offset) begin
          $error("word_offset: expected %h, got %h", exp_px.word_offset,
                 out_data.word_offset);
          fail_count++;
        end
        if (out_data.inside_res !== exp_px.inside_res) begin
          $error("inside_res: expected %b, got %b", exp_px.inside_res, out_data.inside_res);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (coord_queue.size() > 0 || expected_pixels.size() > 0 || start) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(tpg_pkg::reg_idx_t idx, logic [tpg_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tpg_pkg::ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tpg_pkg::REG_FRAME_WIDTH:  frame_w_cfg = value[12:0];
      tpg_pkg::REG_FRAME_HEIGHT: frame_h_cfg = value[12:0];
      tpg_pkg::REG_ROW_PITCH:    pitch_cfg = value[13:0];
      tpg_pkg::REG_BLUE_FIRST:   bgr_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned p, bit bgr);
    wait_drained();
    write_reg(tpg_pkg::REG_FRAME_WIDTH, tpg_pkg::DATA_W'(w));
    write_reg(tpg_pkg::REG_FRAME_HEIGHT, tpg_pkg::DATA_W'(h));
    write_reg(tpg_pkg::REG_ROW_PITCH, tpg_pkg::DATA_W'(p));
    write_reg(tpg_pkg::REG_BLUE_FIRST, tpg_pkg::DATA_W'(bgr));
  endtask

  task automatic add_coord(int unsigned x, int unsigned y);
    tpg_pkg::in_t c;
    c.pixel_x = tpg_pkg::COORD_W'(x);
    c.pixel_y = tpg_pkg::COORD_W'(y);
    coord_queue.push_back(c);
  endtask

  function automatic int unsigned pick_coord(int unsigned raw_extent, int unsigned max_ext);
    int unsigned e;
    int unsigned sel;
    e = (raw_extent > max_ext) ? max_ext : raw_extent;
    sel = $urandom_range(0, 99);
    if (e == 0 || sel < 15) begin
      return $urandom_range(0, 4095);
    end
    if (sel < 30) begin
      case ($urandom_range(0, 11))
        0:       return 0;
        1:       return e - 1;
        2:       return e;
        3:       return e / 3;
        4:       return (e * 2) / 3 - 1;
        5:       return (e * 2) / 3;
        6:       return e / 6 - 1;
        7:       return e / 6;
        8:       return (e * 5) / 6 - 1;
        9:       return (e * 5) / 6;
        10:      return CHECKER - 1;
        default: return CHECKER;
      endcase
    end
    return $urandom_range(0, e - 1);
  endfunction

  task automatic run_random(int unsigned count, bit pause_midway);
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) begin
        wait_drained();
      end
      add_coord(pick_coord(frame_w_cfg, MAX_W), pick_coord(frame_h_cfg, MAX_H));
    end
  endtask

  initial begin
    int unsigned idle_set[3];
    int unsigned w;
    int unsigned h;
    idle_set = '{0, 50, 11};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry 640 x 480: corners, band edges, checker edges, bit patterns.
    add_coord(0, 0);
    add_coord(4095, 4095);
    add_coord(639, 479);
    add_coord(640, 0);
    add_coord(0, 480);
    add_coord(1, 1);
    add_coord(106, 160);
    add_coord(105, 160);
    add_coord(533, 319);
    add_coord(534, 319);
    add_coord(106, 159);
    add_coord(300, 320);
    add_coord(47, 1);
    add_coord(48, 1);
    add_coord(48, 48);
    add_coord(96, 49);
    add_coord(12'hAAA, 12'h555);
    add_coord(12'h555, 12'hAAA);
    add_coord(12'h2AA, 12'h155);
    add_coord(12'h155, 12'h0AA);
    add_coord(639, 200);
    add_coord(200, 0);
    run_random(100, 1'b0);

    set_geometry(1, 1, 1, 1'b1);
    sender_idle_pct = 50;
    run_random(80, 1'b0);

    set_geometry(4096, 4096, 16383, 1'b1);
    sender_idle_pct = 11;
    run_random(120, 1'b1);

    set_geometry(8191, 8191, 8192, 1'b0);
    sender_idle_pct = 0;
    run_random(100, 1'b0);

    set_geometry(0, 0, 0, 1'b1);
    sender_idle_pct = 50;
    run_random(60, 1'b0);

    set_geometry(2, 3, 2, 1'b0);
    sender_idle_pct = 11;
    run_random(80, 1'b0);

    set_geometry(100, 97, 120, 1'b1);
    sender_idle_pct = 0;
    run_random(100, 1'b0);

    for (int unsigned k = 0; k < 8; k++) begin
      w = (k % 2 == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4096);
      h = (k % 3 == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4096);
      set_geometry(w, h, (k == 5) ? $urandom_range(0, w) : w + $urandom_range(0, 4096),
                   $urandom_range(0, 1));
      sender_idle_pct = idle_set[k % 3];
      run_random(95, 1'b0);
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/tpg_pkg.sv
rtl/tpg_div_cell.sv
rtl/test_pattern_pixel_generator_top.sv
dv/test_pattern_pixel_generator_top_tb.sv
